@@ src/plo_pkg.sv @@
// Shared widths, operation and status codes, and the cell control type.
`timescale 1ns / 1ps

package plo_pkg;

   localparam int FUNC_W   = 2;
   localparam int ID_W     = 32;
   localparam int SIZE_W   = 32;
   localparam int VOL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_MODIFY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic search;
      logic do_add;
      logic do_remove;
      logic do_modify;
   } ctrl_type;

endpackage

@@ src/plo_cell.sv @@
// One slot of the order row: holds an id and a size and shifts toward the head on remove.
`timescale 1ns / 1ps

module plo_cell
   import plo_pkg::*;
(
   input  logic              clock,
   input  ctrl_type          ctrl,
   input  logic              occupied,
   input  logic              is_tail,
   input  logic [ID_W-1:0]   req_id,
   input  logic [SIZE_W-1:0] req_size,
   input  logic [ID_W-1:0]   next_id,
   input  logic [SIZE_W-1:0] next_size,
   input  logic              shift_in,
   output logic              shift_out,
   output logic [ID_W-1:0]   id,
   output logic [SIZE_W-1:0] size,
   output logic              match,
   output logic [SIZE_W-1:0] match_size
);

   logic [ID_W-1:0]   id_ff;
   logic [ID_W-1:0]   id_in;
   logic [SIZE_W-1:0] size_ff;
   logic [SIZE_W-1:0] size_in;
   logic              hit_ff;
   logic              hit_in;

   assign match      = occupied && (id_ff == req_id);
   assign match_size = match ? size_ff : '0;
   assign shift_out  = shift_in | hit_ff;
   assign id         = id_ff;
   assign size       = size_ff;

   always_comb begin
      id_in   = id_ff;
      size_in = size_ff;
      hit_in  = hit_ff;
      if (ctrl.search) begin
         hit_in = match;
      end
      if (ctrl.do_add && is_tail) begin
         id_in   = req_id;
         size_in = req_size;
      end
      if (ctrl.do_modify && hit_ff) begin
         size_in = req_size;
      end
      if (ctrl.do_remove && shift_out) begin
         id_in   = next_id;
         size_in = next_size;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      size_ff <= size_in;
      hit_ff  <= hit_in;
   end

endmodule

@@ src/plo_row.sv @@
// The row of order cells with occupancy decode and the match collection.
`timescale 1ns / 1ps

module plo_row
   import plo_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
)(
   input  logic              clock,
   input  ctrl_type          ctrl,
   input  logic [CNT_W-1:0]  count,
   input  logic [ID_W-1:0]   req_id,
   input  logic [SIZE_W-1:0] req_size,
   output logic              any_match,
   output logic [SIZE_W-1:0] match_size
);

   logic [ID_W-1:0]   cell_id    [CAPACITY];
   logic [SIZE_W-1:0] cell_size  [CAPACITY];
   logic [SIZE_W-1:0] cell_msize [CAPACITY];
   logic [CAPACITY-1:0] cell_match;
   logic [CAPACITY:0]   shift_chain;

   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ID_W-1:0]   nxt_id;
      logic [SIZE_W-1:0] nxt_size;

      if (i == CAPACITY - 1) begin : g_last
         assign nxt_id   = cell_id[i];
         assign nxt_size = cell_size[i];
      end else begin : g_mid
         assign nxt_id   = cell_id[i+1];
         assign nxt_size = cell_size[i+1];
      end

      plo_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CNT_W'(i) < count),
         .is_tail    (CNT_W'(i) == count),
         .req_id     (req_id),
         .req_size   (req_size),
         .next_id    (nxt_id),
         .next_size  (nxt_size),
         .shift_in   (shift_chain[i]),
         .shift_out  (shift_chain[i+1]),
         .id         (cell_id[i]),
         .size       (cell_size[i]),
         .match      (cell_match[i]),
         .match_size (cell_msize[i])
      );
   end

   assign any_match = |cell_match;

   always_comb begin
      match_size = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_size = match_size | cell_msize[i];
      end
   end

endmodule

@@ src/price_level_order_table.sv @@
// Top level of the price level order table: control, volume and count, result register.
//
//   channel   direction  handshake              payload
//   request   in         start high, busy low   req_func, req_order_id, req_order_size
//   response  out        rsp_valid, one cycle   rsp_ok, rsp_status, rsp_total_volume,
//                                               rsp_order_count
//
// A transaction passes through a search state, in which every cell compares its id,
// then a commit state in which the cells shift, append or resize and the volume is updated.
// The next transaction is accepted during the commit state, so a new request can be taken while the last commits.
// The response appears on the cycle after commit and cannot be stalled by the receiver.
// Reset clears the entry count, the volume and the control state; cell contents are not
// cleared and are read only after being written.
`timescale 1ns / 1ps

module price_level_order_table
   import plo_pkg::*;
#(
   parameter int CAPACITY = 64
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ID_W-1:0]     req_order_id,
   input  logic [SIZE_W-1:0]   req_order_size,
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VOL_W-1:0]    rsp_total_volume,
   output logic [COUNT_W-1:0]  rsp_order_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   logic [FUNC_W-1:0]   func_ff;
   logic [ID_W-1:0]     id_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [VOL_W-1:0]    vol_ff;
   logic [VOL_W-1:0]    vol_in;
   logic                any_hit_ff;
   logic [SIZE_W-1:0]   hit_size_ff;
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic                rsp_ok_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;

   logic                accept;
   logic                commit;
   ctrl_type            ctrl;
   logic                row_match;
   logic [SIZE_W-1:0]   row_size;
   logic [VOL_W-1:0]    vol_less;
   logic [VOL_W-1:0]    add_base;
   logic [VOL_W:0]      add_sum;
   logic [VOL_W-1:0]    vol_plus;

   assign busy   = (state_ff == S_SEARCH);
   assign accept = start && !busy;
   assign commit = (state_ff == S_COMMIT);

   assign vol_less = (hit_size_ff > vol_ff) ? '0 : (vol_ff - hit_size_ff);
   assign add_base = (func_ff == FN_MODIFY) ? vol_less : vol_ff;
   assign add_sum  = {1'b0, add_base} + {1'b0, size_ff};
   assign vol_plus = add_sum[VOL_W] ? '1 : add_sum[VOL_W-1:0];

   always_comb begin
      ctrl           = '0;
      ctrl.search    = (state_ff == S_SEARCH);
      count_in       = count_ff;
      vol_in         = vol_ff;
      rsp_ok_in      = 1'b0;
      rsp_status_in  = ST_MISS;
      unique case (func_ff)
         FN_ADD: begin
            if (any_hit_ff) begin
               rsp_status_in = ST_MISS;
            end else if (count_ff >= CNT_W'(CAPACITY)) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctrl.do_add   = commit;
               count_in      = count_ff + 1'b1;
               vol_in        = vol_plus;
               rsp_ok_in     = 1'b1;
               rsp_status_in = ST_DONE;
            end
         end
         FN_REMOVE: begin
            if (count_ff == '0) begin
               rsp_ok_in     = 1'b1;
               rsp_status_in = ST_EMPTY;
            end else if (any_hit_ff) begin
               ctrl.do_remove = commit;
               count_in       = count_ff - 1'b1;
               vol_in         = vol_less;
               rsp_ok_in      = 1'b1;
               rsp_status_in  = ST_DONE;
            end
         end
         FN_MODIFY: begin
            if (any_hit_ff) begin
               ctrl.do_modify = commit;
               vol_in         = vol_plus;
               rsp_ok_in      = 1'b1;
               rsp_status_in  = ST_DONE;
            end
         end
         default: begin
            rsp_status_in = ST_MISS;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   state_in = accept ? S_SEARCH : S_IDLE;
         S_SEARCH: state_in = S_COMMIT;
         S_COMMIT: state_in = accept ? S_SEARCH : S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   plo_row #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_row (
      .clock      (clock),
      .ctrl       (ctrl),
      .count      (count_ff),
      .req_id     (id_ff),
      .req_size   (size_ff),
      .any_match  (row_match),
      .match_size (row_size)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         vol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= commit;
         if (commit) begin
            count_ff <= count_in;
            vol_ff   <= vol_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         id_ff   <= req_order_id;
         size_ff <= req_order_size;
      end
      if (ctrl.search) begin
         any_hit_ff  <= row_match;
         hit_size_ff <= row_size;
      end
      if (commit) begin
         rsp_ok_ff     <= rsp_ok_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_total_volume = vol_ff;
   assign rsp_order_count  = COUNT_W'(count_ff);

`ifndef SYNTHESIS
   a_search_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("search phase lasted more than one cycle");

   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy, 2))
      else $error("response without a preceding search");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");
`endif

endmodule
